// ----- hdl/jhsh_pkg.sv -----
// package for the jpeg huffman symbol histogram unit
// action and operation codes, queue entry type, category helpers
// no dependencies
package jhsh_pkg;

  localparam int ComponentSlots = 4;
  localparam int EntriesPerComp = 512;
  localparam int QueueDepth     = 4;
  localparam int RunW           = 6;
  localparam int CountOutW      = 32;

  localparam logic       TableDc = 1'b0;
  localparam logic       TableAc = 1'b1;
  localparam logic [7:0] SymZrl  = 8'hF0;
  localparam logic [7:0] SymEob  = 8'h00;

  typedef enum logic [1:0] {
    ACT_COEF  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_BUMP  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_kind_e;

  typedef enum logic {
    BK_SWEEP = 1'b0,
    BK_RUN   = 1'b1
  } back_state_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [1:0] comp;
    logic       table_kind;
    logic [7:0] sym;
    logic [1:0] incr;
    logic       zero;
  } op_t;

  typedef struct packed {
    logic clearing;
    logic read_fire;
  } back_status_t;

  function automatic op_t make_op(input op_kind_e kind, input logic [1:0] comp,
                                  input logic table_kind, input logic [7:0] sym,
                                  input logic [1:0] incr, input logic zero);
    op_t o;
    o.kind       = kind;
    o.comp       = comp;
    o.table_kind = table_kind;
    o.sym        = sym;
    o.incr       = incr;
    o.zero       = zero;
    return o;
  endfunction

  function automatic logic [14:0] magnitude(input logic signed [15:0] v);
    logic [15:0] neg;
    neg = -v;
    return v[15] ? neg[14:0] : v[14:0];
  endfunction

  function automatic logic [3:0] size_category(input logic [14:0] mag);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 15; b++) begin
      if (mag[b]) n = 4'(b + 1);
    end
    return n;
  endfunction

endpackage

// ----- hdl/jhsh_channels.sv -----
// handshake channels of the jpeg huffman symbol histogram unit
// item channel carries actions and coefficients, result channel carries counts
// depends on jhsh_pkg
interface jhsh_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [1:0]        component;
  logic signed [14:0] coefficient;
  logic              table_kind;
  logic [7:0]        symbol;

  modport source (output valid, action, component, coefficient, table_kind, symbol,
                  input ready);
  modport sink (input valid, action, component, coefficient, table_kind, symbol,
                output ready);
endinterface

interface jhsh_result_if;
  import jhsh_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CountOutW-1:0] count;

  modport source (output valid, count, input ready);
  modport sink (input valid, count, output ready);
endinterface

// ----- hdl/jhsh_front.sv -----
// front end: accepts requests, tracks block position, zero run and dc predictors
// turns each request into up to two histogram operations for the queue
// depends on jhsh_pkg
module jhsh_front #(
  parameter int NUM_COMPONENTS = 4,
  parameter int BLOCK_COEFFS   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [1:0]         action_i,
  input  logic [1:0]         component_i,
  input  logic signed [14:0] coefficient_i,
  input  logic               table_kind_i,
  input  logic [7:0]         symbol_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output jhsh_pkg::op_t      push_op_o
);
  import jhsh_pkg::*;

  localparam int PosW = $clog2(BLOCK_COEFFS);

  logic [PosW-1:0]    pos_q, pos_d;
  logic [RunW-1:0]    run_q, run_d;
  logic signed [14:0] pred_q [ComponentSlots];
  logic signed [14:0] pred_d [ComponentSlots];
  op_t                op0_q, op0_d, op1_q, op1_d;
  logic [1:0]         cnt_q, cnt_d;

  logic push_fire, accept;

  assign push_valid_o = (cnt_q != 2'd0);
  assign push_op_o    = op0_q;
  assign push_fire    = push_valid_o && push_ready_i;
  assign ready_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && push_fire);
  assign accept       = valid_i && ready_o;

  always_comb begin
    logic              known;
    logic              last;
    logic [RunW-1:0]   run_next;
    logic [3:0]        cat;
    logic signed [15:0] diff;
    op_t               n0, n1;
    logic [1:0]        nops;
    pos_d    = pos_q;
    run_d    = run_q;
    pred_d   = pred_q;
    op0_d    = op0_q;
    op1_d    = op1_q;
    cnt_d    = cnt_q;
    known    = int'(component_i) < NUM_COMPONENTS;
    last     = (pos_q == PosW'(BLOCK_COEFFS - 1));
    run_next = run_q;
    diff     = 16'(coefficient_i) - 16'(pred_q[component_i]);
    cat      = '0;
    n0       = make_op(OP_BUMP, component_i, TableAc, SymEob, 2'd1, 1'b0);
    n1       = n0;
    nops     = 2'd0;
    if (push_fire) begin
      op0_d = op1_q;
      cnt_d = cnt_q - 2'd1;
    end
    if (accept) begin
      unique case (action_e'(action_i))
        ACT_CLEAR: begin
          pos_d  = '0;
          run_d  = '0;
          for (int c = 0; c < ComponentSlots; c++) pred_d[c] = '0;
          n0     = make_op(OP_CLEAR, component_i, table_kind_i, symbol_i, 2'd0, 1'b0);
          nops   = 2'd1;
        end
        ACT_READ: begin
          n0   = make_op(OP_READ, component_i, table_kind_i, symbol_i, 2'd0, !known);
          nops = 2'd1;
        end
        ACT_COEF: begin
          if (known) begin
            if (pos_q == '0) begin
              cat                 = size_category(magnitude(diff));
              n0                  = make_op(OP_BUMP, component_i, TableDc, {4'd0, cat},
                                            2'd1, 1'b0);
              nops                = 2'd1;
              pred_d[component_i] = coefficient_i;
            end else if (coefficient_i == '0) begin
              run_next = run_q + RunW'(1);
            end else begin
              cat      = size_category(magnitude(16'(coefficient_i)));
              run_next = '0;
              if (run_q[5:4] != 2'd0) begin
                n0   = make_op(OP_BUMP, component_i, TableAc, SymZrl, run_q[5:4], 1'b0);
                n1   = make_op(OP_BUMP, component_i, TableAc, {run_q[3:0], cat}, 2'd1,
                               1'b0);
                nops = 2'd2;
              end else begin
                n0   = make_op(OP_BUMP, component_i, TableAc, {run_q[3:0], cat}, 2'd1,
                               1'b0);
                nops = 2'd1;
              end
            end
            if (last) begin
              if (run_next != '0) begin
                if (nops == 2'd0) begin
                  n0 = make_op(OP_BUMP, component_i, TableAc, SymEob, 2'd1, 1'b0);
                end else begin
                  n1 = make_op(OP_BUMP, component_i, TableAc, SymEob, 2'd1, 1'b0);
                end
                nops = nops + 2'd1;
              end
              pos_d = '0;
              run_d = '0;
            end else begin
              pos_d = pos_q + PosW'(1);
              run_d = run_next;
            end
          end
        end
        default: ;
      endcase
      op0_d = n0;
      op1_d = n1;
      cnt_d = nops;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      run_q <= '0;
      cnt_q <= '0;
      for (int c = 0; c < ComponentSlots; c++) pred_q[c] <= '0;
    end else begin
      pos_q  <= pos_d;
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      pred_q <= pred_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op0_q <= op0_d;
    op1_q <= op1_d;
  end

endmodule

// ----- hdl/jhsh_op_fifo.sv -----
// short operation queue between front end and histogram back end
// depends on jhsh_pkg
module jhsh_op_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  jhsh_pkg::op_t push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output jhsh_pkg::op_t pop_op_o
);
  import jhsh_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  op_t             entries_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;
  logic            push, pop;

  assign push_ready_o = (fill_q != (PtrW + 1)'(QueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_op_o     = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push && !pop) begin
        fill_q <= fill_q + (PtrW + 1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (PtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_op_i;
  end

endmodule

// ----- hdl/jhsh_back.sv -----
// back end: histogram memory with pipelined read-modify-write and clearing sweep
// read results go to an output register
// depends on jhsh_pkg
module jhsh_back #(
  parameter int NUM_COMPONENTS = 4,
  parameter int COUNT_BITS     = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  jhsh_pkg::op_t                 pop_op_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [jhsh_pkg::CountOutW-1:0] count_o,
  output jhsh_pkg::back_status_t        status_o
);
  import jhsh_pkg::*;

  localparam int Depth = NUM_COMPONENTS * EntriesPerComp;
  localparam int AddrW = $clog2(Depth);

  logic [COUNT_BITS-1:0] mem [Depth];

  back_state_e           state_q, state_d;
  logic [AddrW-1:0]      sweep_addr_q;
  logic                  s2_valid_q;
  op_t                   s2_op_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  fwd_valid_q;
  logic [AddrW-1:0]      fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic                  out_valid_q;
  logic [CountOutW-1:0]  out_count_q;

  logic [AddrW-1:0]      head_addr, s2_addr;
  logic [COUNT_BITS-1:0] cur, bumped;
  logic [COUNT_BITS:0]   sum;
  logic [CountOutW-1:0]  cur_sat;
  logic                  s2_read, s2_bump, s2_adv, pop, pop_clear, sweep_done;

  assign head_addr  = AddrW'({pop_op_i.comp, pop_op_i.table_kind, pop_op_i.sym});
  assign s2_addr    = AddrW'({s2_op_q.comp, s2_op_q.table_kind, s2_op_q.sym});
  assign cur        = (fwd_valid_q && (fwd_addr_q == s2_addr)) ? fwd_data_q : rdata_q;
  assign sum        = {1'b0, cur} + (COUNT_BITS + 1)'(s2_op_q.incr);
  assign bumped     = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign s2_read    = s2_valid_q && (s2_op_q.kind == OP_READ);
  assign s2_bump    = s2_valid_q && (s2_op_q.kind == OP_BUMP);
  assign s2_adv     = s2_valid_q && (!s2_read || !out_valid_q || ready_i);
  assign pop_ready_o = (state_q == BK_RUN) && (!s2_valid_q || s2_adv);
  assign pop        = pop_valid_i && pop_ready_o;
  assign pop_clear  = pop && (pop_op_i.kind == OP_CLEAR);
  assign sweep_done = (sweep_addr_q == AddrW'(Depth - 1));

  generate
    if (COUNT_BITS > CountOutW) begin : g_sat
      assign cur_sat = (|cur[COUNT_BITS-1:CountOutW]) ? '1 : cur[CountOutW-1:0];
    end else begin : g_ext
      assign cur_sat = CountOutW'(cur);
    end
  endgenerate

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_SWEEP: if (sweep_done) state_d = BK_RUN;
      BK_RUN:   if (pop_clear) state_d = BK_SWEEP;
      default:  state_d = BK_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_SWEEP;
      sweep_addr_q <= '0;
      s2_valid_q   <= 1'b0;
      fwd_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_SWEEP) begin
        sweep_addr_q <= sweep_addr_q + AddrW'(1);
      end else begin
        sweep_addr_q <= '0;
      end
      if (pop) begin
        s2_valid_q <= !pop_clear;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (pop_clear || state_q == BK_SWEEP) begin
        fwd_valid_q <= 1'b0;
      end else if (s2_adv && s2_bump) begin
        fwd_valid_q <= 1'b1;
      end
      if (s2_adv && s2_read) begin
        out_valid_q <= 1'b1;
      end else if (ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_SWEEP) begin
      mem[sweep_addr_q] <= '0;
    end else if (s2_adv && s2_bump) begin
      mem[s2_addr] <= bumped;
    end
    if (pop) begin
      rdata_q <= mem[head_addr];
      s2_op_q <= pop_op_i;
    end
    if (s2_adv && s2_bump) begin
      fwd_addr_q <= s2_addr;
      fwd_data_q <= bumped;
    end
    if (s2_adv && s2_read) out_count_q <= s2_op_q.zero ? '0 : cur_sat;
  end

  assign valid_o            = out_valid_q;
  assign count_o            = out_count_q;
  assign status_o.clearing  = (state_q == BK_SWEEP);
  assign status_o.read_fire = s2_adv && s2_read;

endmodule

// ----- hdl/jpeg_huffman_symbol_histogram_unit.sv -----
// Collects baseline JPEG Huffman symbol statistics from quantized coefficients in
// zigzag order and returns per-component DC/AC symbol counts on read requests. The
// front end takes one request per cycle while the queue accepts, if a coefficient yields
// one update; one yielding two (a ZRL batch and its run/size symbol) holds off the next
// request until the second is pushed. The back end retires one read-modify-write per
// cycle, unless a read waits on an unaccepted result, via a registered memory read with
// write forwarding; reads pass the front-end op register, the queue, the read stage and
// the output register. After reset and each clear the back end sweeps NUM_COMPONENTS*512
// entries, one per cycle, while requests still fill the four-entry queue and front end.
// Depends on jhsh_pkg, jhsh_channels, jhsh_front, jhsh_op_fifo and jhsh_back.
module jpeg_huffman_symbol_histogram_unit #(
  parameter int NUM_COMPONENTS = 4,
  parameter int BLOCK_COEFFS   = 64,
  parameter int COUNT_BITS     = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  jhsh_item_if.sink    item_i,
  jhsh_result_if.source result_o
);
  import jhsh_pkg::*;

  logic         push_valid, push_ready, pop_valid, pop_ready;
  op_t          push_op, pop_op;
  back_status_t back_status;

  jhsh_front #(
    .NUM_COMPONENTS(NUM_COMPONENTS),
    .BLOCK_COEFFS  (BLOCK_COEFFS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (item_i.valid),
    .ready_o      (item_i.ready),
    .action_i     (item_i.action),
    .component_i  (item_i.component),
    .coefficient_i(item_i.coefficient),
    .table_kind_i (item_i.table_kind),
    .symbol_i     (item_i.symbol),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  jhsh_op_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_op_i   (push_op),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_op_o    (pop_op)
  );

  jhsh_back #(
    .NUM_COMPONENTS(NUM_COMPONENTS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_op_i   (pop_op),
    .valid_o    (result_o.valid),
    .ready_i    (result_o.ready),
    .count_o    (result_o.count),
    .status_o   (back_status)
  );

  // no queue entry leaves while the histogram is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_status.clearing |-> !(pop_valid && pop_ready))
    else $error("queue popped during clearing sweep");

  // a stalled front end holds its pending operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && !push_ready) |=> (push_valid && $stable(push_op)))
    else $error("front end dropped a pending operation");

  // a result is only raised by a read leaving the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(back_status.read_fire))
    else $error("result without read");

endmodule

// ----- tb/sv/jhsh_tb_pkg.sv -----
// software copy of the symbol histogram unit, with a queue of read counts still due
// notes each accepted request and checks every returned count in order
// depends on jhsh_pkg
package jhsh_tb_pkg;
  import jhsh_pkg::*;

  localparam int NumComponents = 4;
  localparam int BlockCoeffs   = 64;
  localparam int CountBits     = 32;
  localparam int ReportLimit   = 10;

  localparam logic [1:0] ActIgnored = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         component;
    logic signed [14:0] coefficient;
    logic               table_kind;
    logic [7:0]         symbol;
  } request_t;

  class huffman_count_tracker;
    logic [CountBits-1:0] counts [ComponentSlots*EntriesPerComp];
    logic signed [14:0]   dc_pred [ComponentSlots];
    int unsigned          position;
    int unsigned          zero_run;
    logic [CountOutW-1:0] expected_counts [$];
    int unsigned          mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      foreach (counts[i]) counts[i] = '0;
      foreach (dc_pred[i]) dc_pred[i] = '0;
      position = 0;
      zero_run = 0;
    endfunction

    function int unsigned category(input int v);
      int unsigned mag;
      int unsigned n;
      mag = (v < 0) ? -v : v;
      n = 0;
      while (mag != 0) begin
        n++;
        mag >>= 1;
      end
      return n;
    endfunction

    function void bump(input logic [1:0] comp, input logic tbl, input logic [7:0] sym,
                       input int unsigned k);
      logic [10:0] idx;
      logic [63:0] cur;
      logic [63:0] top;
      idx = {comp, tbl, sym};
      cur = 64'(counts[idx]);
      top = (64'd1 << CountBits) - 64'd1;
      if (64'(k) >= top - cur) counts[idx] = CountBits'(top);
      else counts[idx] = CountBits'(cur + 64'(k));
    endfunction

    function void add_coefficient(input logic [1:0] comp, input logic signed [14:0] coef);
      int unsigned zrl;
      logic [3:0]  run;
      logic [3:0]  size;
      if (comp >= NumComponents) return;
      if (position == 0) begin
        bump(comp, TableDc, 8'(category(int'(coef) - int'(dc_pred[comp]))), 1);
        dc_pred[comp] = coef;
      end else if (coef == 0) begin
        zero_run = (zero_run + 1) & 6'h3F;
      end else begin
        zrl  = zero_run / 16;
        run  = 4'(zero_run % 16);
        size = 4'(category(int'(coef)));
        if (zrl != 0) bump(comp, TableAc, SymZrl, zrl);
        bump(comp, TableAc, {run, size}, 1);
        zero_run = 0;
      end
      if (position + 1 >= BlockCoeffs) begin
        if (zero_run != 0) bump(comp, TableAc, SymEob, 1);
        position = 0;
        zero_run = 0;
      end else begin
        position = (position + 1) & 6'h3F;
      end
    endfunction

    function void take_request(input request_t req);
      logic [63:0] c;
      if (req.action == ACT_CLEAR) begin
        wipe();
      end else if (req.action == ACT_READ) begin
        c = '0;
        if (req.component < NumComponents)
          c = 64'(counts[{req.component, req.table_kind, req.symbol}]);
        if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
        expected_counts.insert(expected_counts.size(), CountOutW'(c));
      end else if (req.action == ACT_COEF) begin
        add_coefficient(req.component, req.coefficient);
      end
    endfunction

    function void check_count(input logic [CountOutW-1:0] actual);
      logic [CountOutW-1:0] want;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unrequested count returned: got %0d", actual);
        return;
      end
      want = expected_counts.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("count mismatch: expected %0d, got %0d", want, actual);
      end
    endfunction

    function void check_drained();
      if (expected_counts.size() != 0) begin
        if (mismatches < ReportLimit)
          $display("%0d read counts never returned", expected_counts.size());
        mismatches += expected_counts.size();
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_jpeg_huffman_symbol_histogram_unit.sv -----
// testbench top for the jpeg huffman symbol histogram unit
// drives coefficient, read and clear requests with random gaps, checks read counts
// depends on jhsh_pkg, jhsh_channels and jhsh_tb_pkg
module tb_jpeg_huffman_symbol_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jhsh_pkg::*;
  import jhsh_tb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  jhsh_item_if   item_bus();
  jhsh_result_if result_bus();

  jpeg_huffman_symbol_histogram_unit #(
    .NUM_COMPONENTS(NumComponents),
    .BLOCK_COEFFS  (BlockCoeffs),
    .COUNT_BITS    (CountBits)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  huffman_count_tracker histogram;
  int unsigned          accepted_items = 0;
  bit                   quiet_send = 1'b0;
  bit                   quiet_recv = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic request_t coef_request(input logic [1:0] comp,
                                            input logic signed [14:0] coef);
    request_t r;
    r = request_t'($urandom);
    r.action      = ACT_COEF;
    r.component   = comp;
    r.coefficient = coef;
    return r;
  endfunction

  function automatic request_t read_request(input logic [1:0] comp, input logic tbl,
                                            input logic [7:0] sym);
    request_t r;
    r = request_t'($urandom);
    r.action     = ACT_READ;
    r.component  = comp;
    r.table_kind = tbl;
    r.symbol     = sym;
    return r;
  endfunction

  function automatic request_t control_request(input logic [1:0] act);
    request_t r;
    r = request_t'($urandom);
    r.action = act;
    return r;
  endfunction

  // reads aimed mostly at symbols the stream can produce
  function automatic request_t random_read();
    logic       tbl;
    logic [7:0] sym;
    int unsigned pick;
    tbl  = 1'($urandom);
    pick = $urandom_range(0, 7);
    if (pick == 0) sym = 8'($urandom);
    else if (tbl == TableDc) sym = 8'($urandom_range(0, 15));
    else if (pick == 1) sym = SymZrl;
    else if (pick == 2) sym = SymEob;
    else sym = {4'($urandom_range(0, 15)), 4'($urandom_range(1, 15))};
    return read_request(2'($urandom), tbl, sym);
  endfunction

  function automatic logic signed [14:0] random_nonzero();
    int unsigned cat;
    int          mag;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0:       return 15'h3FFF;
        1:       return 15'h4001;
        default: return 15'h4000;
      endcase
    end
    cat = $urandom_range(1, 14);
    mag = $urandom_range((1 << cat) - 1, 1 << (cat - 1));
    return $urandom_range(0, 1) ? 15'(-mag) : 15'(mag);
  endfunction

  task automatic send_request(input request_t req);
    int unsigned gap;
    gap = quiet_send ? 0 : $urandom_range(0, 19);
    repeat (gap) begin
      @(negedge clk_i);
      item_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    item_bus.valid       <= 1'b1;
    item_bus.action      <= req.action;
    item_bus.component   <= req.component;
    item_bus.coefficient <= req.coefficient;
    item_bus.table_kind  <= req.table_kind;
    item_bus.symbol      <= req.symbol;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
    histogram.take_request(req);
    if (req.action != ActIgnored) accepted_items++;
  endtask

  task automatic receive_counts();
    int unsigned stall;
    forever begin
      stall = quiet_recv ? 0 : $urandom_range(0, 19);
      repeat (stall) begin
        @(negedge clk_i);
        result_bus.ready <= 1'b0;
      end
      @(negedge clk_i);
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (result_bus.valid !== 1'b1);
      histogram.check_count(result_bus.count);
    end
  endtask

  // one block of coefficients, finishing a partial one if the stream is mid-block
  task automatic run_block();
    int unsigned        sparsity;
    logic [1:0]         comp;
    bit                 mixed;
    bit                 end_hot;
    bit                 last;
    logic signed [14:0] coef;
    case ($urandom_range(0, 3))
      0:       sparsity = 2;
      1:       sparsity = 6;
      2:       sparsity = 20;
      default: sparsity = 70;
    endcase
    comp       = 2'($urandom);
    mixed      = ($urandom_range(0, 7) == 0);
    end_hot    = ($urandom_range(0, 3) == 0);
    quiet_send = ($urandom_range(0, 3) == 0);
    quiet_recv = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 14) == 0) send_request(control_request(ACT_CLEAR));
    do begin
      if (mixed) comp = 2'($urandom);
      last = (histogram.position == BlockCoeffs - 1);
      if (histogram.position == 0) begin
        case ($urandom_range(0, 5))
          0:       coef = '0;
          1:       coef = histogram.dc_pred[comp];
          default: coef = random_nonzero();
        endcase
      end else if ((last && end_hot) || $urandom_range(1, sparsity) == 1) begin
        coef = random_nonzero();
      end else begin
        coef = '0;
      end
      send_request(coef_request(comp, coef));
      if ($urandom_range(0, 5) == 0) send_request(random_read());
      if ($urandom_range(0, 59) == 0) send_request(control_request(ActIgnored));
      if ($urandom_range(0, 299) == 0) send_request(control_request(ACT_CLEAR));
    end while (histogram.position != 0);
    repeat ($urandom_range(1, 4)) send_request(random_read());
  endtask

  initial begin
    histogram = new();
    rst_ni                = 1'b0;
    item_bus.valid        = 1'b0;
    item_bus.action       = ACT_COEF;
    item_bus.component    = '0;
    item_bus.coefficient  = '0;
    item_bus.table_kind   = TableDc;
    item_bus.symbol       = '0;
    result_bus.ready      = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    fork
      receive_counts();
    join_none

    // directed: extremes, tag switch mid-block, unused action, clear
    send_request(read_request(2'd0, TableDc, 8'd0));
    send_request(coef_request(2'd0, 15'h3FFF));
    send_request(coef_request(2'd0, '0));
    send_request(coef_request(2'd0, '0));
    send_request(coef_request(2'd1, 15'h4000));
    send_request(coef_request(2'd2, 15'sd1));
    send_request(control_request(ActIgnored));
    send_request(read_request(2'd0, TableDc, 8'd14));
    send_request(read_request(2'd1, TableAc, 8'h2F));
    send_request(read_request(2'd2, TableAc, 8'h01));
    send_request(read_request(2'd3, TableAc, 8'hFF));
    send_request(control_request(ACT_CLEAR));
    send_request(read_request(2'd0, TableDc, 8'd14));
    send_request(coef_request(2'd3, 15'h4000));
    send_request(coef_request(2'd3, 15'h7FFF));
    send_request(read_request(2'd3, TableDc, 8'd15));
    send_request(read_request(2'd3, TableAc, 8'h01));

    while (accepted_items < 950) run_block();
    @(negedge clk_i);
    item_bus.valid <= 1'b0;

    while (histogram.expected_counts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    histogram.check_drained();
    if (histogram.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/jhsh_pkg.sv
hdl/jhsh_channels.sv
hdl/jhsh_front.sv
hdl/jhsh_op_fifo.sv
hdl/jhsh_back.sv
hdl/jpeg_huffman_symbol_histogram_unit.sv
tb/sv/jhsh_tb_pkg.sv
tb/sv/tb_jpeg_huffman_symbol_histogram_unit.sv
